// ===== hdl/pcsb_pkg.sv =====
// shared types and constants for the pixel contrast / saturation / brightness block
// no dependencies; imported by pcsb_pivot_stage and the top level
package pcsb_pkg;

    // one rgb pixel, red in the low byte
    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_pix;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_STAGE_ENABLE    = 2'd0,
        REG_CONTRAST_GAIN   = 2'd1,
        REG_SATURATION_GAIN = 2'd2,
        REG_BRIGHTNESS_GAIN = 2'd3
    } t_cfg_reg;

    localparam int GAIN_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int PROD_W  = CHAN_W + GAIN_W;
    localparam int FRAC_W  = 8;

    localparam logic [GAIN_W-1:0] GAIN_ONE       = 16'd256;
    localparam logic [CHAN_W-1:0] CONTRAST_PIVOT = 8'd128;
    localparam logic [CHAN_W-1:0] CHANNEL_MAX    = 8'd255;
    localparam logic [CHAN_W-1:0] ZERO_PIVOT     = 8'd0;

    // floor(s / 3) for s < 2048 as (s * 683) >> 11
    localparam int            SUM_W       = 10;
    localparam logic [9:0]    MEAN_RECIP  = 10'd683;
    localparam int            MEAN_SHIFT  = 11;

    // stage bits
    localparam int EN_CONTRAST   = 0;
    localparam int EN_SATURATION = 1;
    localparam int EN_BRIGHTNESS = 2;

    // pipeline registers between input and output
    localparam int PIPE_DEPTH = 7;

endpackage

// ===== hdl/pcsb_pivot_stage.sv =====
// two-register pivot scaling stage: (c - pivot) * gain / 256 + pivot, clamped to 0..255;
// zero gain gives 0 and a disabled stage passes the pixel through; depends on pcsb_pkg
module pcsb_pivot_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [15:0]    i_gain,
    input  logic           i_valid,
    output logic           o_ready,
    input  pcsb_pkg::t_pix i_pix,
    input  logic [7:0]     i_pivot,
    output logic           o_valid,
    input  logic           i_ready,
    output pcsb_pkg::t_pix o_pix
);
    import pcsb_pkg::*;

    // multiply register
    logic                r_v1;
    logic [PROD_W-1:0]   r_prod [3];
    logic [2:0]          r_neg;
    logic [CHAN_W-1:0]   r_pivot;
    t_pix                r_pix1;
    // result register
    logic                r_v2;
    t_pix                r_pix2;

    logic                w_rdy1;
    logic                w_rdy2;
    logic [CHAN_W-1:0]   w_chan [3];
    logic [PROD_W-1:0]   n_prod [3];
    logic [2:0]          n_neg;
    logic [CHAN_W-1:0]   w_res  [3];
    t_pix                n_pix2;

    function automatic logic [CHAN_W-1:0] finish(
        input logic [PROD_W-1:0] prod,
        input logic              neg,
        input logic [CHAN_W-1:0] pivot
    );
        logic [GAIN_W-1:0]   q;
        logic [GAIN_W:0]     sum;
        logic [CHAN_W-1:0]   res;
        q   = prod[PROD_W-1:FRAC_W];
        sum = {1'b0, q} + {{(GAIN_W-CHAN_W+1){1'b0}}, pivot};
        if (neg) begin
            if (q > {{(GAIN_W-CHAN_W){1'b0}}, pivot}) begin
                res = '0;
            end else begin
                res = pivot - q[CHAN_W-1:0];
            end
        end else if (sum > {{(GAIN_W-CHAN_W+1){1'b0}}, CHANNEL_MAX}) begin
            res = CHANNEL_MAX;
        end else begin
            res = sum[CHAN_W-1:0];
        end
        return res;
    endfunction

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_pix   = r_pix2;

    assign w_chan[0] = i_pix.r;
    assign w_chan[1] = i_pix.g;
    assign w_chan[2] = i_pix.b;

    // magnitude of the offset from the pivot times the gain
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_neg[k]  = w_chan[k] < i_pivot;
            n_prod[k] = (n_neg[k] ? {16'd0, i_pivot - w_chan[k]}
                                  : {16'd0, w_chan[k] - i_pivot}) * i_gain;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_res[k] = (i_gain == '0) ? '0 : finish(r_prod[k], r_neg[k], r_pivot);
        end
        if (i_en) begin
            n_pix2 = '{b: w_res[2], g: w_res[1], r: w_res[0]};
        end else begin
            n_pix2 = r_pix1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_prod  <= n_prod;
            r_neg   <= n_neg;
            r_pivot <= i_pivot;
            r_pix1  <= i_pix;
        end
        if (w_rdy2 && r_v1) begin
            r_pix2 <= n_pix2;
        end
    end

endmodule

// ===== hdl/pixel_contrast_saturation_brightness.sv =====
// top level of the pixel contrast / saturation / brightness adjust pipeline
// depends on pcsb_pkg and pcsb_pivot_stage
//
// channel      dir   request moved                     tdata / payload bits
// s_axis       in    one rgb pixel                     [7:0] red [15:8] green [23:16] blue
// m_axis       out   one adjusted rgb pixel            [7:0] red [15:8] green [23:16] blue
// cfg          in    register write (index, data)      index 0..3, data [15:0]
//
// one pixel per clock sustained while the output is not stalled; from input request
// to output request a pixel passes two registers per scaling stage (multiply, then
// shift and clamp) plus one register for the channel mean ahead of saturation
// reset (synchronous, active low) clears all valid bits and loads the register defaults
// each register stage holds its request while the next one is full and stalled, so a
// backpressured output fills the pipe before the input side deasserts ready
module pixel_contrast_saturation_brightness (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in from bit 0 up
    // pixel out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out from bit 0 up
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pcsb_pkg::*;

    // configuration registers
    logic [2:0]        r_stage_en;
    logic [GAIN_W-1:0] r_con_gain;
    logic [GAIN_W-1:0] r_sat_gain;
    logic [GAIN_W-1:0] r_bri_gain;

    // contrast stage outputs
    logic              w_con_valid;
    logic              w_con_ready;
    t_pix              w_con_pix;

    // mean register ahead of saturation
    logic              r_m_valid;
    t_pix              r_m_pix;
    logic [CHAN_W-1:0] r_m_mean;
    logic              w_m_ready;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W+9:0]  w_mean_prod;

    // saturation stage outputs
    logic              w_sat_ready;
    logic              w_sat_valid;
    logic              w_bri_ready;
    t_pix              w_sat_pix;
    t_pix              w_out_pix;

    // requests in flight, for checking only
    logic [3:0]        r_inflight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_en <= '0;
            r_con_gain <= GAIN_ONE;
            r_sat_gain <= GAIN_ONE;
            r_bri_gain <= GAIN_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_STAGE_ENABLE:    r_stage_en <= i_cfg_data[2:0];
                REG_CONTRAST_GAIN:   r_con_gain <= i_cfg_data;
                REG_SATURATION_GAIN: r_sat_gain <= i_cfg_data;
                REG_BRIGHTNESS_GAIN: r_bri_gain <= i_cfg_data;
                default:             r_stage_en <= r_stage_en;
            endcase
        end
    end

    // contrast around mid gray
    pcsb_pivot_stage u_contrast (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_stage_en[EN_CONTRAST]),
        .i_gain  (r_con_gain),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (t_pix'(s_axis_tdata)),
        .i_pivot (CONTRAST_PIVOT),
        .o_valid (w_con_valid),
        .i_ready (w_con_ready),
        .o_pix   (w_con_pix)
    );

    // integer mean of the three channels, divide by 3 as a reciprocal multiply
    assign w_sum       = {2'b0, w_con_pix.r} + {2'b0, w_con_pix.g} + {2'b0, w_con_pix.b};
    assign w_mean_prod = w_sum * MEAN_RECIP;
    assign w_m_ready   = !r_m_valid || w_sat_ready;
    assign w_con_ready = w_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_m_ready) begin
            r_m_valid <= w_con_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_ready && w_con_valid) begin
            r_m_pix  <= w_con_pix;
            r_m_mean <= w_mean_prod[MEAN_SHIFT+CHAN_W-1:MEAN_SHIFT];
        end
    end

    // saturation around the channel mean
    pcsb_pivot_stage u_saturation (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_stage_en[EN_SATURATION]),
        .i_gain  (r_sat_gain),
        .i_valid (r_m_valid),
        .o_ready (w_sat_ready),
        .i_pix   (r_m_pix),
        .i_pivot (r_m_mean),
        .o_valid (w_sat_valid),
        .i_ready (w_bri_ready),
        .o_pix   (w_sat_pix)
    );

    // brightness is the same scaling with the pivot at zero
    pcsb_pivot_stage u_brightness (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_stage_en[EN_BRIGHTNESS]),
        .i_gain  (r_bri_gain),
        .i_valid (w_sat_valid),
        .o_ready (w_bri_ready),
        .i_pix   (w_sat_pix),
        .i_pivot (ZERO_PIVOT),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (w_out_pix)
    );

    assign m_axis_tdata = w_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight
                        + {3'b0, s_axis_tvalid && s_axis_tready}
                        - {3'b0, m_axis_tvalid && m_axis_tready};
        end
    end

    // pipe never holds more pixels than it has registers
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 4'(PIPE_DEPTH))
        else $error("pixel count in pipe exceeds register stages");

    // an output request always stands for an accepted pixel
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 4'd0)
        else $error("output request with no pixel in pipe");

    // input side only stalls when the output side is holding a request
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a full pipe with a stalled output cannot take more pixels
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 4'(PIPE_DEPTH)) && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted into a full stalled pipe");

endmodule
